@@ src/local_maximum_peak_selector_unit_assert.svh @@
// Assertion macros of the peak selector sequencer.
`ifndef LOCAL_MAXIMUM_PEAK_SELECTOR_UNIT_ASSERT_SVH
`define LOCAL_MAXIMUM_PEAK_SELECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMPS_ASSERT_HOLDS(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("lmps: same-cycle check violated");

// Consequent must hold in the cycle after the antecedent.
`define LMPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("lmps: next-cycle check violated");

`endif

@@ src/lmps_pkg.sv @@
// Package: constants, codes and types of the peak selector.
`timescale 1ns / 1ps
package lmps_pkg;

    localparam int MAX_SERIES = 1024;
    localparam int IDX_W      = $clog2(MAX_SERIES);
    localparam int POS_W      = 11;
    localparam int REACH_W    = 10;
    localparam int SCORE_W    = 32;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Opcodes of an input request
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_LEFT_REACH    = 2'd0;
    localparam logic [1:0] REG_RIGHT_REACH   = 2'd1;
    localparam logic [1:0] REG_SERIES_LENGTH = 2'd2;

    localparam logic [POS_W-1:0] SERIES_LENGTH_RST = POS_W'(1024);
    localparam logic [POS_W-1:0] MAX_SERIES_POS    = POS_W'(MAX_SERIES);

    typedef struct packed {
        logic [REACH_W-1:0] left_reach;
        logic [REACH_W-1:0] right_reach;
        logic [POS_W-1:0]   series_length;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [SCORE_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LATCH,
        ST_SCAN
    } state_t;

endpackage

@@ src/lmps_if.sv @@
// Request and result channel interfaces of the peak selector.
`timescale 1ns / 1ps
interface lmps_in_if
    import lmps_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [IDX_W-1:0]          load_index;
    logic signed [SCORE_W-1:0] score_value;
    logic [POS_W-1:0]          candidate_position;

    modport source (
        output valid, op, load_index, score_value, candidate_position,
        input  ready
    );
    modport sink (
        input  valid, op, load_index, score_value, candidate_position,
        output ready
    );
endinterface

interface lmps_out_if
    import lmps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] tested_position;
    logic             accepted;
    logic             out_of_range;

    modport source (
        output valid, tested_position, accepted, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, tested_position, accepted, out_of_range,
        output ready
    );
endinterface

@@ src/lmps_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/lmps_cfg.sv @@
// APB register block: reach and length settings.
`timescale 1ns / 1ps
module lmps_cfg
    import lmps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_LEFT_REACH:    cfg_next.left_reach    = pwdata[REACH_W-1:0];
                REG_RIGHT_REACH:   cfg_next.right_reach   = pwdata[REACH_W-1:0];
                REG_SERIES_LENGTH: cfg_next.series_length = pwdata[POS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LEFT_REACH:    prdata = PDATA_W'(cfg_reg.left_reach);
            REG_RIGHT_REACH:   prdata = PDATA_W'(cfg_reg.right_reach);
            REG_SERIES_LENGTH: prdata = PDATA_W'(cfg_reg.series_length);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_reach    <= '0;
            cfg_reg.right_reach   <= '0;
            cfg_reg.series_length <= SERIES_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/lmps_scan.sv @@
// Sequencer and shared compare unit: loads scores, scans candidate windows.
`timescale 1ns / 1ps
`include "local_maximum_peak_selector_unit_assert.svh"
module lmps_scan
    import lmps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    lmps_in_if.sink            in_ch,
    lmps_out_if.source         out_ch,
    output mem_req_t           mem_req,
    input  logic [SCORE_W-1:0] rd_data
);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   k_reg, k_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [POS_W-1:0]   issue_p_reg, issue_p_next;
    logic [SCORE_W-1:0] pivot_reg, pivot_next;
    logic               out_vld_reg, out_vld_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               out_acc_reg, out_acc_next;
    logic               out_oor_reg, out_oor_next;

    logic               in_ready;
    logic               in_acc;
    logic [POS_W-1:0]   len_eff;
    logic [POS_W-1:0]   k_in;
    logic [POS_W-1:0]   k_in_m1;
    logic [POS_W-1:0]   win_lo;
    logic [POS_W-1:0]   win_sum;
    logic [POS_W-1:0]   win_hi;
    logic               cand_oor;
    logic               greater;
    logic [POS_W-1:0]   lo_m1;
    logic [POS_W-1:0]   issue_m1;

    assign len_eff  = (cfg.series_length > MAX_SERIES_POS) ? MAX_SERIES_POS
                                                           : cfg.series_length;
    assign k_in     = in_ch.candidate_position;
    assign k_in_m1  = k_in - POS_W'(1);
    assign cand_oor = (k_in == '0) || (k_in > len_eff);
    assign win_lo   = (k_in > POS_W'(cfg.left_reach)) ? k_in - POS_W'(cfg.left_reach)
                                                      : POS_W'(1);
    assign win_sum  = k_in + POS_W'(cfg.right_reach);
    assign win_hi   = (win_sum > len_eff) ? len_eff : win_sum;
    assign lo_m1    = lo_reg - POS_W'(1);
    assign issue_m1 = issue_p_reg - POS_W'(1);

    // shared compare unit: stored score against the pivot
    assign greater  = $signed(rd_data) > $signed(pivot_reg);

    assign in_ready = (state_reg == ST_IDLE) && (!out_vld_reg || out_ch.ready);
    assign in_acc   = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    assign out_ch.valid           = out_vld_reg;
    assign out_ch.tested_position = out_pos_reg;
    assign out_ch.accepted        = out_acc_reg;
    assign out_ch.out_of_range    = out_oor_reg;

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        issue_p_next  = issue_p_reg;
        pivot_next    = pivot_reg;
        out_vld_next  = out_vld_reg && !out_ch.ready;
        out_pos_next  = out_pos_reg;
        out_acc_next  = out_acc_reg;
        out_oor_next  = out_oor_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = in_ch.load_index;
        mem_req.wdata = in_ch.score_value;
        mem_req.raddr = k_in_m1[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.op == OP_LOAD)
                    begin
                        mem_req.we = ({1'b0, in_ch.load_index} < (IDX_W + 1)'(MAX_SERIES));
                    end
                    else if (cand_oor)
                    begin
                        out_vld_next = 1'b1;
                        out_pos_next = k_in;
                        out_acc_next = 1'b0;
                        out_oor_next = 1'b1;
                    end
                    else
                    begin
                        // pivot read is issued this cycle
                        k_next     = k_in;
                        lo_next    = win_lo;
                        hi_next    = win_hi;
                        state_next = ST_LATCH;
                    end
                end
            end
            ST_LATCH:
            begin
                pivot_next    = rd_data;
                mem_req.raddr = lo_m1[IDX_W-1:0];
                issue_p_next  = lo_reg + POS_W'(1);
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                mem_req.raddr = issue_m1[IDX_W-1:0];
                if (greater || (issue_p_reg > hi_reg))
                begin
                    out_vld_next = 1'b1;
                    out_pos_next = k_reg;
                    out_acc_next = !greater;
                    out_oor_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    issue_p_next = issue_p_reg + POS_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        issue_p_reg <= issue_p_next;
        pivot_reg   <= pivot_next;
        out_pos_reg <= out_pos_next;
        out_acc_reg <= out_acc_next;
        out_oor_reg <= out_oor_next;
    end

    `LMPS_ASSERT_HOLDS(window_holds_pivot_a, clk, rst_n, state_reg != ST_IDLE, lo_reg <= k_reg && k_reg <= hi_reg && lo_reg != '0)
    `LMPS_ASSERT_HOLDS(scan_ptr_in_window_a, clk, rst_n, state_reg == ST_SCAN, issue_p_reg > lo_reg && issue_p_reg <= hi_reg + POS_W'(1))
    `LMPS_ASSERT_NEXT(scan_end_posts_result_a, clk, rst_n, state_reg == ST_SCAN && state_next == ST_IDLE, out_vld_reg && !out_oor_reg && out_pos_reg == $past(k_reg))
    `LMPS_ASSERT_HOLDS(accept_only_in_range_a, clk, rst_n, out_vld_reg && out_acc_reg, !out_oor_reg && out_pos_reg != '0)

endmodule

@@ src/local_maximum_peak_selector_unit.sv @@
// Top level of the windowed local-maximum peak selector.
`timescale 1ns / 1ps
// Usage:
//   Requests arrive on in_ch (valid/ready). op = load writes score_value into
//   the score store at load_index and gives no result. op = test checks the
//   one-based candidate_position and gives one result on out_ch: the position,
//   accepted (no score in the window is strictly greater) and out_of_range.
//   Settings (left_reach, right_reach, series_length) are written over APB at
//   byte addresses 0, 4 and 8; write them only while the block is idle.
// Sequencing:
//   A load is written to the store as it is accepted. An out-of-range test
//   posts its result in the cycle after acceptance. An in-range test reads the
//   pivot, then walks its window one stored score per cycle through the single
//   RAM read port and compare unit; a greater score ends the walk early, and
//   the result is valid in the cycle after the walk ends.
//   in_ch.ready stays low for the whole walk.
// Reset:
//   Clears the sequencer and the result valid; reaches go to 0, the length
//   to 1024. Store contents stay undefined until loaded.
// Receiver stall:
//   The result holds in the output register; in_ch.ready stays low for loads
//   and tests alike until the pending result is taken.
module local_maximum_peak_selector_unit
    import lmps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    lmps_in_if.sink            in_ch,
    lmps_out_if.source         out_ch
);

    cfg_t               cfg;
    mem_req_t           mem_req;
    logic [SCORE_W-1:0] rd_data;

    // Settings registers
    lmps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer with the shared compare unit; drives the store ports
    lmps_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Score store: one write port for loads, one registered read port for scans
    lmps_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_SERIES)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

endmodule

@@ tb/sv/testbench.sv @@
// Testbench of the peak selector: a directed table, then random phases checked against a predictor.
`timescale 1ns / 1ps
module testbench;
    import lmps_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 3;
    // A load gives no result; wait before touching the registers so that the
    // last one has surely landed.
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 150;
    // Slowest correct stall: a full 1024-entry walk behind a long receiver
    // hold-off and a sender gap; take it many times over.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASES          = 7;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          load_index;
        logic signed [SCORE_W-1:0] score_value;
        logic [POS_W-1:0]          candidate_position;
    } request_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             accepted;
        logic             out_of_range;
    } verdict_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_TEST,
        ROW_SET
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         reg_index;
        logic [31:0]        value;
        logic [IDX_W-1:0]   index;
        logic [POS_W-1:0]   position;
        logic               typed;
        logic               accepted;
        logic               out_of_range;
    } script_row_t;

    // Clock, reset and the APB side
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lmps_in_if  in_ch();
    lmps_out_if out_ch();

    local_maximum_peak_selector_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Predictor state: a private copy of the score store, which entries hold
    // a loaded score, and the three settings.
    logic signed [SCORE_W-1:0] score_copy [MAX_SERIES];
    bit                        loaded     [MAX_SERIES];
    logic [REACH_W-1:0]        reach_left;
    logic [REACH_W-1:0]        reach_right;
    logic [POS_W-1:0]          series_len;

    verdict_t    pending_verdicts[$];
    script_row_t script[$];

    // Run bookkeeping
    int  failures        = 0;
    int  reported        = 0;
    int  loads_sent      = 0;
    int  tests_sent      = 0;
    int  settings_written = 0;
    int  peaks_seen      = 0;
    int  rejects_seen    = 0;
    int  outside_seen    = 0;
    int  quiet_cycles    = 0;
    int  focus           = 1;
    int  hold_tickets    = 0;
    bit  tail_quiet      = 1'b0;

    int phase_left   [PHASES] = '{1, 4, 0, 1023, 3, 2, 6};
    int phase_right  [PHASES] = '{1, 2, 7, 1023, 5, 3, 0};
    int phase_length [PHASES] = '{1024, 64, 300, 12, 1, 2047, 1024};
    int phase_items  [PHASES] = '{90, 90, 80, 60, 30, 80, 120};

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Effective length: the length setting saturates at the store depth.
    function automatic int span();
        return (series_len > MAX_SERIES_POS) ? MAX_SERIES : int'(series_len);
    endfunction

    // Window of candidate k, clamped to 1..span.
    function automatic void reach_window(input int k, output int lo, output int hi);
        lo = (k > int'(reach_left)) ? k - int'(reach_left) : 1;
        hi = k + int'(reach_right);
        if (hi > span())
            hi = span();
    endfunction

    // Judge one candidate: out of range, or a peak when nothing in its window
    // is strictly greater (ties still count as a peak).
    function automatic verdict_t judge_candidate(input logic [POS_W-1:0] k);
        verdict_t v;
        int       lo;
        int       hi;
        v.position     = k;
        v.accepted     = 1'b0;
        v.out_of_range = 1'b0;
        if (k == 0 || int'(k) > span())
        begin
            v.out_of_range = 1'b1;
            return v;
        end
        reach_window(int'(k), lo, hi);
        v.accepted = 1'b1;
        for (int p = lo; p <= hi; p++)
        begin
            if (score_copy[p-1] > score_copy[k-1])
                v.accepted = 1'b0;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic script_row_t load_row(input logic [IDX_W-1:0] idx,
                                             input logic [31:0] score);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_LOAD;
        row.index = idx;
        row.value = score;
        return row;
    endfunction

    function automatic script_row_t test_row(input logic [POS_W-1:0] pos);
        script_row_t row;
        row          = '0;
        row.kind     = ROW_TEST;
        row.position = pos;
        return row;
    endfunction

    // A test whose verdict is obvious enough to type in.
    function automatic script_row_t typed_row(input logic [POS_W-1:0] pos,
                                              input logic acc, input logic oor);
        script_row_t row;
        row              = test_row(pos);
        row.typed        = 1'b1;
        row.accepted     = acc;
        row.out_of_range = oor;
        return row;
    endfunction

    function automatic script_row_t set_row(input logic [1:0] which, input logic [31:0] value);
        script_row_t row;
        row           = '0;
        row.kind      = ROW_SET;
        row.reg_index = which;
        row.value     = value;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Scores: mostly a few half-step levels so that ties and near misses are
    // common, plus the extremes and raw random words for bit coverage.
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return SCORE_W'((int'($urandom_range(0, 8)) - 4) * 32768);
        endcase
    endfunction

    // Build one random request. Most are tests around a slowly moving focus;
    // when the window of the chosen candidate still holds an entry that was
    // never loaded, load that entry instead so that no unloaded score is read.
    task automatic draw_request(output request_t r);
        int cap;
        int k;
        int lo;
        int hi;
        int hole;
        cap = span();
        // Fill the unused fields with noise.
        r.op                 = OP_TEST;
        r.load_index         = IDX_W'($urandom());
        r.score_value        = $urandom();
        r.candidate_position = POS_W'($urandom());
        case ($urandom_range(0, 7))
            0:
            begin
                r.op          = OP_LOAD;
                r.score_value = pick_score();
            end
            1:
            begin
                r.candidate_position = ($urandom_range(0, 3) == 0) ? '0
                                       : POS_W'($urandom_range(cap + 1, 2047));
            end
            default:
            begin
                if (cap == 0)
                    return;
                if ($urandom_range(0, 15) == 0 || focus > cap)
                    focus = $urandom_range(1, cap);
                k = focus + int'($urandom_range(0, 12)) - 6;
                if (k < 1)
                    k = 1;
                if (k > cap)
                    k = cap;
                reach_window(k, lo, hi);
                hole = 0;
                for (int p = lo; p <= hi && hole == 0; p++)
                begin
                    if (!loaded[p-1])
                        hole = p;
                end
                if (hole != 0 || $urandom_range(0, 5) == 0)
                begin
                    // Fill the hole, or refresh the candidate's own score.
                    r.op          = OP_LOAD;
                    r.load_index  = IDX_W'(((hole != 0) ? hole : k) - 1);
                    r.score_value = pick_score();
                end
                else
                begin
                    r.candidate_position = POS_W'(k);
                end
            end
        endcase
    endtask

    // Offer one request and hold it until accepted, then update the predictor.
    // A short random gap may come first; valid drops only across a gap.
    task automatic offer(input request_t r, input bit use_typed, input verdict_t typed_verdict);
        if (!tail_quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.op                 <= r.op;
        in_ch.load_index         <= r.load_index;
        in_ch.score_value        <= r.score_value;
        in_ch.candidate_position <= r.candidate_position;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (r.op == OP_LOAD)
        begin
            score_copy[r.load_index] = r.score_value;
            loaded[r.load_index]     = 1'b1;
            loads_sent++;
        end
        else
        begin
            pending_verdicts.insert(pending_verdicts.size(),
                                    use_typed ? typed_verdict
                                              : judge_candidate(r.candidate_position));
            tests_sent++;
        end
    endtask

    // Drop valid, wait for every expected result, then let a trailing load retire.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge where the access meets pready. psel then drops before the task
    // returns, so that back-to-back writes never assign psel twice in one step.
    task automatic write_register(input logic [1:0] which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (which)
            REG_LEFT_REACH:    reach_left  = value[REACH_W-1:0];
            REG_RIGHT_REACH:   reach_right = value[REACH_W-1:0];
            REG_SERIES_LENGTH: series_len  = value[POS_W-1:0];
            default: ;
        endcase
        settings_written++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-offs on request, checking
    // ------------------------------------------------------------------

    task automatic take_verdict();
        verdict_t got;
        verdict_t want;
        got = {out_ch.tested_position, out_ch.accepted, out_ch.out_of_range};
        if (got.out_of_range === 1'b1)
            outside_seen++;
        else if (got.accepted === 1'b1)
            peaks_seen++;
        else
            rejects_seen++;
        if (pending_verdicts.size() == 0)
        begin
            failures++;
            if (reported < REPORT_LIMIT)
                $display("%0t: unexpected result pos %0d acc %0b oor %0b", $time,
                         got.position, got.accepted, got.out_of_range);
            reported++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.position !== want.position || got.accepted !== want.accepted
            || got.out_of_range !== want.out_of_range)
        begin
            failures++;
            if (reported < REPORT_LIMIT)
                $display("%0t: mismatch: expected pos %0d acc %0b oor %0b, got pos %0d acc %0b oor %0b",
                         $time, want.position, want.accepted, want.out_of_range,
                         got.position, got.accepted, got.out_of_range);
            reported++;
        end
    endtask

    initial
    begin : result_sink
        int stall;
        int holds_served;
        stall        = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_ch.valid && out_ch.ready)
                    take_verdict();
                // Decide ready for the next cycle: finish a stall, start a
                // long hold-off when one is asked for, or stall briefly at random.
                if (stall > 0)
                begin
                    stall--;
                    out_ch.ready <= 1'b0;
                end
                else if (hold_tickets > holds_served)
                begin
                    holds_served++;
                    stall = HOLD_OFF_CYCLES - 1;
                    out_ch.ready <= 1'b0;
                end
                else if (!tail_quiet && $urandom_range(0, 9) == 0)
                begin
                    stall = $urandom_range(0, 2);
                    out_ch.ready <= 1'b0;
                end
                else
                begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: any accepted request, result or register write restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        request_t r;
        verdict_t typed;

        // Drive every input to a known value and mirror the reset settings.
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        in_ch.valid              <= 1'b0;
        in_ch.op                 <= OP_LOAD;
        in_ch.load_index         <= '0;
        in_ch.score_value        <= '0;
        in_ch.candidate_position <= '0;
        reach_left  = '0;
        reach_right = '0;
        series_len  = SERIES_LENGTH_RST;
        foreach (loaded[i])
        begin
            loaded[i]     = 1'b0;
            score_copy[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Opens on the reset settings (no reach, length 1024),
        // then a small hand-built series for ties, strict maxima, clamping to
        // the length, a zero length and a saturated length.
        script = '{
            typed_row(11'd0,    1'b0, 1'b1),
            typed_row(11'd1025, 1'b0, 1'b1),
            typed_row(11'd2047, 1'b0, 1'b1),
            load_row(10'd1023, 32'h7FFF_FFFF),
            typed_row(11'd1024, 1'b1, 1'b0),
            load_row(10'd0, 32'h8000_0000),
            typed_row(11'd1,    1'b1, 1'b0),
            set_row(REG_LEFT_REACH, 32'd3),
            set_row(REG_RIGHT_REACH, 32'd2),
            load_row(10'd1, 32'h0001_0000),
            load_row(10'd2, 32'h0001_0000),
            load_row(10'd3, 32'h0000_8000),
            load_row(10'd4, 32'hFFFF_0000),
            load_row(10'd5, 32'h0002_0000),
            load_row(10'd6, 32'h0002_0000),
            load_row(10'd7, 32'h0001_FFFF),
            test_row(11'd2),
            test_row(11'd1),
            test_row(11'd4),
            test_row(11'd6),
            set_row(REG_SERIES_LENGTH, 32'd6),
            typed_row(11'd7,    1'b0, 1'b1),
            test_row(11'd6),
            set_row(REG_SERIES_LENGTH, 32'd0),
            typed_row(11'd1,    1'b0, 1'b1),
            set_row(REG_SERIES_LENGTH, 32'd2047),
            typed_row(11'd1025, 1'b0, 1'b1),
            test_row(11'd5)
        };

        foreach (script[i])
        begin
            r       = '0;
            typed   = {script[i].position, script[i].accepted, script[i].out_of_range};
            case (script[i].kind)
                ROW_SET:
                begin
                    settle();
                    write_register(script[i].reg_index, script[i].value);
                end
                ROW_LOAD:
                begin
                    r.op          = OP_LOAD;
                    r.load_index  = script[i].index;
                    r.score_value = script[i].value;
                    offer(r, 1'b0, typed);
                end
                default:
                begin
                    r.op                 = OP_TEST;
                    r.candidate_position = script[i].position;
                    offer(r, script[i].typed, typed);
                end
            endcase
        end

        // Random phases, each under its own settings: both reaches at their
        // maximum against a short series, a length of one, a saturated length.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_register(REG_LEFT_REACH, phase_left[ph]);
            write_register(REG_RIGHT_REACH, phase_right[ph]);
            write_register(REG_SERIES_LENGTH, phase_length[ph]);
            // Run the last phase with no idling on either side.
            if (ph == PHASES - 1)
                tail_quiet <= 1'b1;
            for (int n = 0; n < phase_items[ph]; n++)
            begin
                // Ask the receiver for a long hold-off while requests keep
                // coming, so that a result backs up and the input stalls.
                if (n == 20 && (ph == 0 || ph == 5))
                    hold_tickets <= hold_tickets + 1;
                draw_request(r);
                offer(r, 1'b0, '0);
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d score loads and %0d candidate tests under %0d register writes",
                 loads_sent, tests_sent, settings_written);
        $display("Results: %0d peaks, %0d rejected, %0d out of range, %0d failures",
                 peaks_seen, rejects_seen, outside_seen, failures);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/lmps_pkg.sv
src/lmps_if.sv
src/lmps_ram.sv
src/lmps_cfg.sv
src/lmps_scan.sv
src/local_maximum_peak_selector_unit.sv
tb/sv/testbench.sv
